@@ rtl/slx_pkg.sv @@
// slx_pkg: shared types, constants and helper functions of the script lexer
// depends on nothing; imported by every module of the lexer
package slx_pkg;

    // position counters, saturating at all ones
    localparam int POS_BITS = 16;
    typedef logic [POS_BITS-1:0] t_pos;
    localparam t_pos POS_ONE = t_pos'(1);
    localparam t_pos POS_MAX = {POS_BITS{1'b1}};

    // record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        M_IDLE,
        M_COMMENT,
        M_LT,
        M_GT,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_ESCAPE,
        M_ERROR
    } t_mode;

    typedef enum logic [1:0] {
        REC_TEXT,
        REC_DONE,
        REC_ERR
    } t_kind;

    // token codes
    localparam logic [4:0] TK_LPAREN = 5'd0;
    localparam logic [4:0] TK_RPAREN = 5'd1;
    localparam logic [4:0] TK_PLUS   = 5'd2;
    localparam logic [4:0] TK_MINUS  = 5'd3;
    localparam logic [4:0] TK_STAR   = 5'd4;
    localparam logic [4:0] TK_SLASH  = 5'd5;
    localparam logic [4:0] TK_ASSIGN = 5'd6;
    localparam logic [4:0] TK_GT     = 5'd7;
    localparam logic [4:0] TK_LT     = 5'd8;
    localparam logic [4:0] TK_LE     = 5'd9;
    localparam logic [4:0] TK_GE     = 5'd10;
    localparam logic [4:0] TK_IDENT  = 5'd11;
    localparam logic [4:0] TK_STRING = 5'd12;
    localparam logic [4:0] TK_INT    = 5'd13;
    localparam logic [4:0] TK_DOUBLE = 5'd14;
    localparam logic [4:0] TK_FLOAT  = 5'd15;
    localparam logic [4:0] TK_NONE   = 5'd0;

    // number kinds, added to TK_INT
    localparam logic [1:0] NK_INT    = 2'd0;
    localparam logic [1:0] NK_DOUBLE = 2'd1;
    localparam logic [1:0] NK_FLOAT  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_CHAR   = 2'd1;
    localparam logic [1:0] ERR_EOF    = 2'd2;
    localparam logic [1:0] ERR_ESCAPE = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // keyword table; spellings right-aligned in a 16 byte field
    localparam int KW_COUNT = 12;
    localparam int KW_CHARS = 16;
    typedef logic [KW_COUNT-1:0] t_kw;
    localparam t_kw KW_ALL = {KW_COUNT{1'b1}};
    localparam logic [8*KW_CHARS-1:0] KW_SPELL [KW_COUNT] = '{
        "mod", "while", "if", "cond", "and", "or", "invokenative",
        "return", "setvalue", "statics", "locals", "fn"};
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd3, 4'd2, 4'd12, 4'd6, 4'd8, 4'd7, 4'd6, 4'd2};
    localparam logic [4:0] KW_CODE [KW_COUNT] = '{
        5'd16, 5'd17, 5'd16, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
        5'd25, 5'd26};

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_kind      rec_kind;
        logic [4:0] token_code;
        logic [7:0] text_char;
        t_pos       pos_line;
        t_pos       pos_column;
        logic [1:0] error_code;
        logic       last_of_run;
    } t_out_rec;

    // one queue entry: all records caused by one input beat
    typedef struct packed {
        t_out_rec rec0;
        t_out_rec rec1;
        logic     two;
    } t_entry;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic t_out_rec mk_rec(input t_kind kind, input logic [4:0] code,
                                        input logic [7:0] ch, input t_pos line,
                                        input t_pos col, input logic [1:0] err);
        t_out_rec r;
        r.rec_kind    = kind;
        r.token_code  = code;
        r.text_char   = ch;
        r.pos_line    = line;
        r.pos_column  = col;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // drop keywords whose spelling does not have c at position len
    function automatic t_kw kw_step(input t_kw m, input logic [3:0] len,
                                    input logic [7:0] c);
        t_kw        r;
        logic [3:0] idx;
        r = m;
        for (int k = 0; k < KW_COUNT; k++) begin
            idx = KW_LEN[k] - 4'd1 - len;
            if (len >= KW_LEN[k] || KW_SPELL[k][{idx, 3'b000} +: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] ident_code(input t_kw m, input logic [3:0] len);
        logic [4:0] code;
        code = TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (m[k] && KW_LEN[k] == len) begin
                code = KW_CODE[k];
            end
        end
        return code;
    endfunction

endpackage

@@ rtl/slx_front.sv @@
// slx_front: accepts source characters, runs the lexing mode machine and
// pushes the records of each beat as one queue entry; uses slx_pkg
module slx_front
    import slx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_stall,
    output logic     o_push,
    output t_entry   o_entry
);

    t_mode      r_mode, n_mode;
    t_pos       r_line, n_line, r_col, n_col;
    t_pos       r_sline, n_sline, r_scol, n_scol;
    t_kw        r_kw, n_kw;
    logic [3:0] r_len, n_len;
    logic       r_dot, n_dot;
    logic [1:0] r_nk, n_nk;

    logic       accept;
    logic [7:0] c;
    logic       eoi;
    logic       restart;
    logic       esc_ok;
    logic [7:0] esc_char;
    logic       a_vld, b_vld;
    t_out_rec   rec_a, rec_b;
    t_out_rec   fin_rec;
    logic       fin_vld;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign c       = i_item.char_in;
    assign eoi     = i_item.end_of_input;

    always_comb begin
        esc_ok   = 1'b1;
        esc_char = c;
        unique case (c)
            CH_LOW_N: esc_char = CH_NL;
            CH_LOW_T: esc_char = CH_TAB;
            CH_BSLASH, CH_QUOTE: esc_char = c;
            default: begin
                esc_ok   = 1'b0;
                esc_char = c;
            end
        endcase
    end

    // character is handled as if the lexer were idle
    always_comb begin
        restart = 1'b0;
        if (!eoi) begin
            unique case (r_mode)
                M_LT, M_GT: restart = (c != CH_EQ);
                M_IDENT:    restart = !(is_alpha(c) || is_digit(c));
                M_NUMBER:   restart = !(is_digit(c) || (c == CH_DOT && !r_dot) ||
                                        c == CH_LOW_F || c == CH_LOW_D);
                M_IDLE:     restart = 1'b1;
                default:    restart = 1'b0;
            endcase
        end
    end

    // pending token completion
    always_comb begin
        fin_vld = 1'b1;
        unique case (r_mode)
            M_IDENT:  fin_rec = mk_rec(REC_DONE, ident_code(r_kw, r_len), CH_NUL,
                                       r_sline, r_scol, ERR_NONE);
            M_NUMBER: fin_rec = mk_rec(REC_DONE, TK_INT + {3'b000, r_nk}, CH_NUL,
                                       r_sline, r_scol, ERR_NONE);
            M_LT:     fin_rec = mk_rec(REC_DONE, TK_LT, CH_NUL, r_sline, r_scol,
                                       ERR_NONE);
            M_GT:     fin_rec = mk_rec(REC_DONE, TK_GT, CH_NUL, r_sline, r_scol,
                                       ERR_NONE);
            default: begin
                fin_vld = 1'b0;
                fin_rec = mk_rec(REC_DONE, TK_NONE, CH_NUL, r_sline, r_scol, ERR_NONE);
            end
        endcase
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_kw    = r_kw;
        n_len   = r_len;
        n_dot   = r_dot;
        n_nk    = r_nk;
        if (eoi) begin
            n_mode  = M_IDLE;
            n_line  = POS_ONE;
            n_col   = POS_ONE;
            n_sline = POS_ONE;
            n_scol  = POS_ONE;
            n_kw    = KW_ALL;
            n_len   = 4'd0;
            n_dot   = 1'b0;
            n_nk    = NK_INT;
        end else begin
            unique case (r_mode)
                M_COMMENT: if (c == CH_NL) n_mode = M_IDLE;
                M_LT, M_GT: if (c == CH_EQ) n_mode = M_IDLE;
                M_IDENT: begin
                    if (!restart) begin
                        n_kw  = kw_step(r_kw, r_len, c);
                        n_len = (r_len == 4'hF) ? r_len : r_len + 4'd1;
                    end
                end
                M_NUMBER: begin
                    if (c == CH_DOT && !r_dot) begin
                        n_dot = 1'b1;
                        n_nk  = NK_DOUBLE;
                    end else if (c == CH_LOW_F) begin
                        n_nk = NK_FLOAT;
                    end else if (c == CH_LOW_D) begin
                        n_nk = NK_DOUBLE;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) n_mode = M_IDLE;
                    else if (c == CH_BSLASH) n_mode = M_ESCAPE;
                end
                M_ESCAPE: n_mode = esc_ok ? M_STRING : M_ERROR;
                default: ;
            endcase
            if (restart) begin
                n_sline = r_line;
                n_scol  = r_col;
                if (c == CH_HASH) n_mode = M_COMMENT;
                else if (c == CH_LT) n_mode = M_LT;
                else if (c == CH_GT) n_mode = M_GT;
                else if (c == CH_QUOTE) n_mode = M_STRING;
                else if (is_alpha(c)) begin
                    n_mode = M_IDENT;
                    n_kw   = kw_step(KW_ALL, 4'd0, c);
                    n_len  = 4'd1;
                end else if (is_digit(c)) begin
                    n_mode = M_NUMBER;
                    n_dot  = 1'b0;
                    n_nk   = NK_INT;
                end else if (is_space(c) || c == CH_LPAREN || c == CH_RPAREN ||
                             c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                             c == CH_SLASH || c == CH_EQ) begin
                    n_mode = M_IDLE;
                end else begin
                    n_mode = M_ERROR;
                end
            end
            if (c == CH_NL) begin
                if (r_line != POS_MAX) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end
    end

    // records of this beat: a from the current mode, b from a restart
    always_comb begin
        a_vld = 1'b0;
        rec_a = fin_rec;
        if (eoi) begin
            if (r_mode == M_STRING || r_mode == M_ESCAPE) begin
                a_vld = 1'b1;
                rec_a = mk_rec(REC_ERR, TK_NONE, CH_NUL, r_sline, r_scol, ERR_EOF);
            end else begin
                a_vld = fin_vld;
            end
        end else begin
            unique case (r_mode)
                M_LT, M_GT: begin
                    a_vld = 1'b1;
                    if (c == CH_EQ) begin
                        rec_a = mk_rec(REC_DONE, (r_mode == M_LT) ? TK_LE : TK_GE,
                                       CH_NUL, r_sline, r_scol, ERR_NONE);
                    end
                end
                M_IDENT: begin
                    a_vld = 1'b1;
                    if (!restart) begin
                        rec_a = mk_rec(REC_TEXT, TK_IDENT, c, r_sline, r_scol, ERR_NONE);
                    end
                end
                M_NUMBER: begin
                    if (restart) begin
                        a_vld = 1'b1;
                    end else if (is_digit(c)) begin
                        a_vld = 1'b1;
                        rec_a = mk_rec(REC_TEXT, TK_INT + {3'b000, r_nk}, c,
                                       r_sline, r_scol, ERR_NONE);
                    end else if (c == CH_DOT) begin
                        a_vld = 1'b1;
                        rec_a = mk_rec(REC_TEXT, TK_DOUBLE, c, r_sline, r_scol,
                                       ERR_NONE);
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        a_vld = 1'b1;
                        rec_a = mk_rec(REC_DONE, TK_STRING, CH_NUL, r_sline, r_scol,
                                       ERR_NONE);
                    end else if (c != CH_BSLASH) begin
                        a_vld = 1'b1;
                        rec_a = mk_rec(REC_TEXT, TK_STRING, c, r_sline, r_scol,
                                       ERR_NONE);
                    end
                end
                M_ESCAPE: begin
                    a_vld = 1'b1;
                    if (esc_ok) begin
                        rec_a = mk_rec(REC_TEXT, TK_STRING, esc_char, r_sline, r_scol,
                                       ERR_NONE);
                    end else begin
                        rec_a = mk_rec(REC_ERR, TK_NONE, c, r_line, r_col, ERR_ESCAPE);
                    end
                end
                default: a_vld = 1'b0;
            endcase
        end

        b_vld = 1'b1;
        rec_b = mk_rec(REC_DONE, TK_NONE, CH_NUL, r_line, r_col, ERR_NONE);
        unique case (c)
            CH_LPAREN: rec_b.token_code = TK_LPAREN;
            CH_RPAREN: rec_b.token_code = TK_RPAREN;
            CH_PLUS:   rec_b.token_code = TK_PLUS;
            CH_MINUS:  rec_b.token_code = TK_MINUS;
            CH_STAR:   rec_b.token_code = TK_STAR;
            CH_SLASH:  rec_b.token_code = TK_SLASH;
            CH_EQ:     rec_b.token_code = TK_ASSIGN;
            CH_HASH, CH_LT, CH_GT, CH_QUOTE: b_vld = 1'b0;
            default: begin
                if (is_space(c)) begin
                    b_vld = 1'b0;
                end else if (is_alpha(c)) begin
                    rec_b = mk_rec(REC_TEXT, TK_IDENT, c, r_line, r_col, ERR_NONE);
                end else if (is_digit(c)) begin
                    rec_b = mk_rec(REC_TEXT, TK_INT, c, r_line, r_col, ERR_NONE);
                end else begin
                    rec_b = mk_rec(REC_ERR, TK_NONE, c, r_line, r_col, ERR_CHAR);
                end
            end
        endcase
        if (!restart) b_vld = 1'b0;
    end

    // pack the beat's records, last one flagged
    always_comb begin
        o_entry.two  = a_vld && b_vld;
        o_entry.rec0 = a_vld ? rec_a : rec_b;
        o_entry.rec1 = rec_b;
        o_entry.rec0.last_of_run = !(a_vld && b_vld);
        o_entry.rec1.last_of_run = 1'b1;
        o_push = accept && (a_vld || b_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_sline <= POS_ONE;
            r_scol  <= POS_ONE;
            r_kw    <= KW_ALL;
            r_len   <= 4'd0;
            r_dot   <= 1'b0;
            r_nk    <= NK_INT;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_kw    <= n_kw;
            r_len   <= n_len;
            r_dot   <= n_dot;
            r_nk    <= n_nk;
        end
    end

endmodule

@@ rtl/slx_queue.sv @@
// slx_queue: short first-in first-out queue of record entries between
// the front and the back of the lexer; uses slx_pkg
module slx_queue
    import slx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);

    t_entry                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QUEUE_PTR_BITS:0]   r_cnt, n_cnt;
    logic                      do_pop;

    localparam logic [QUEUE_PTR_BITS:0] CNT_FULL = (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        if (do_pop) n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        if (i_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

endmodule

@@ rtl/slx_back.sv @@
// slx_back: takes queue entries apart into single records and holds them
// in the output register until the receiver takes the beat; uses slx_pkg
module slx_back
    import slx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_entry   i_entry,
    output logic     o_pop,
    output logic     o_valid,
    output t_out_rec o_rec,
    input  logic     i_stall
);

    logic     r_valid;
    t_out_rec r_rec;
    logic     r_sel, n_sel;
    logic     load;

    assign load    = !r_valid || !i_stall;
    assign o_pop   = load && !i_empty && (r_sel || !i_entry.two);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_comb begin
        n_sel = r_sel;
        if (load && !i_empty) n_sel = !o_pop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (load) r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) r_rec <= r_sel ? i_entry.rec1 : i_entry.rec0;
    end

endmodule

@@ rtl/script_lexer_unit.sv @@
// script_lexer_unit: top level of the streaming script lexer
// depends on slx_pkg, slx_front, slx_queue and slx_back
//
// input channel: one source character beat (i_item) per i_valid with o_stall
//   low; end_of_input finishes the pending token and restarts positions
// output channel: one record beat (o_rec) per o_valid with i_stall low; a
//   character gives zero, one or two records, last_of_run marks the final one
// path: the edge that takes a character writes its records into the queue;
//   the output register takes them from the queue head as it becomes free
// throughput: one character per cycle while i_stall is low and each gives at
//   most one record; a character that gives two records sends them in turn
// the output register and a four entry queue part the channels, so new
//   characters are taken while a finished record waits for the receiver
// receiver stall: the output register holds its beat; once the queue fills,
//   o_stall rises and the front holds the lexing state
// reset (synchronous, active low): lexer idle, line and column at 1, queue
//   empty, no output beat pending
module script_lexer_unit
    import slx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_rec o_rec
);

    // queue hookup
    logic   push;
    t_entry push_entry;
    logic   pop;
    t_entry head_entry;
    logic   q_full;
    logic   q_empty;

    // front: mode machine, keyword match and position counters
    slx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // entries hold all records of one character beat
    slx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: serializes entries into the output register
    slx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_rec   (o_rec),
        .i_stall (i_stall)
    );

endmodule

@@ sim/slx_checker.sv @@
// slx_checker: watches both channels of the script lexer, predicts every record
// from the accepted character beats and compares each record field by field
// depends on slx_pkg for the beat types, mode, kind, token and error names
module slx_checker
    import slx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_rec i_out_rec,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_KEYWORDS  = 12;
    localparam int MAX_REPORTS = 40;

    localparam logic [4:0] TK_KW_IF       = 5'd16;
    localparam logic [4:0] TK_KW_WHILE    = 5'd17;
    localparam logic [4:0] TK_KW_COND     = 5'd18;
    localparam logic [4:0] TK_KW_AND      = 5'd19;
    localparam logic [4:0] TK_KW_OR       = 5'd20;
    localparam logic [4:0] TK_KW_INVOKE   = 5'd21;
    localparam logic [4:0] TK_KW_RETURN   = 5'd22;
    localparam logic [4:0] TK_KW_SETVALUE = 5'd23;
    localparam logic [4:0] TK_KW_STATICS  = 5'd24;
    localparam logic [4:0] TK_KW_LOCALS   = 5'd25;
    localparam logic [4:0] TK_KW_FN       = 5'd26;

    // lexer state as the block should hold it
    t_mode                 lex_state;
    t_pos                  cur_line, cur_col, tok_line, tok_col;
    logic [N_KEYWORDS-1:0] kw_alive;
    logic [3:0]            id_len;
    logic                  saw_dot;
    logic [1:0]            num_kind;

    t_out_rec expected_recs[$];
    int       fail_count = 0;

    // "mod" shares the if code
    function automatic string kw_spelling(input int k);
        case (k)
            0:       return "mod";
            1:       return "while";
            2:       return "if";
            3:       return "cond";
            4:       return "and";
            5:       return "or";
            6:       return "invokenative";
            7:       return "return";
            8:       return "setvalue";
            9:       return "statics";
            10:      return "locals";
            default: return "fn";
        endcase
    endfunction

    function automatic logic [4:0] kw_token(input int k);
        case (k)
            0, 2:    return TK_KW_IF;
            1:       return TK_KW_WHILE;
            3:       return TK_KW_COND;
            4:       return TK_KW_AND;
            5:       return TK_KW_OR;
            6:       return TK_KW_INVOKE;
            7:       return TK_KW_RETURN;
            8:       return TK_KW_SETVALUE;
            9:       return TK_KW_STATICS;
            10:      return TK_KW_LOCALS;
            default: return TK_KW_FN;
        endcase
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c == "_") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    task automatic reset_lexer();
        lex_state = M_IDLE;
        cur_line  = POS_ONE;
        cur_col   = POS_ONE;
        tok_line  = POS_ONE;
        tok_col   = POS_ONE;
        kw_alive  = '1;
        id_len    = '0;
        saw_dot   = 1'b0;
        num_kind  = NK_INT;
    endtask

    task automatic expect_rec(input t_kind kind, input logic [4:0] code,
                              input logic [7:0] ch, input t_pos line, input t_pos col,
                              input logic [1:0] err);
        t_out_rec r;
        r.rec_kind    = kind;
        r.token_code  = code;
        r.text_char   = ch;
        r.pos_line    = line;
        r.pos_column  = col;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        expected_recs.insert(expected_recs.size(), r);
    endtask

    task automatic close_token();
        logic [4:0] code;
        string      s;
        case (lex_state)
            M_IDENT: begin
                code = TK_IDENT;
                for (int k = 0; k < N_KEYWORDS; k++) begin
                    s = kw_spelling(k);
                    if (kw_alive[k] && s.len() == int'(id_len)) begin
                        code = kw_token(k);
                    end
                end
                expect_rec(REC_DONE, code, CH_NUL, tok_line, tok_col, ERR_NONE);
            end
            M_NUMBER: expect_rec(REC_DONE, 5'(TK_INT + num_kind), CH_NUL, tok_line, tok_col,
                                 ERR_NONE);
            M_LT:     expect_rec(REC_DONE, TK_LT, CH_NUL, tok_line, tok_col, ERR_NONE);
            M_GT:     expect_rec(REC_DONE, TK_GT, CH_NUL, tok_line, tok_col, ERR_NONE);
            default: ;
        endcase
    endtask

    // narrow the keyword candidates by one more character
    task automatic take_ident_char(input logic [7:0] c);
        string s;
        for (int k = 0; k < N_KEYWORDS; k++) begin
            s = kw_spelling(k);
            if (int'(id_len) >= s.len() || s[id_len] != c) begin
                kw_alive[k] = 1'b0;
            end
        end
        if (id_len != 4'd15) begin
            id_len++;
        end
        expect_rec(REC_TEXT, TK_IDENT, c, tok_line, tok_col, ERR_NONE);
    endtask

    task automatic start_token(input logic [7:0] c);
        logic [4:0] sym;
        logic       is_sym;
        lex_state = M_IDLE;
        tok_line  = cur_line;
        tok_col   = cur_col;
        is_sym    = 1'b1;
        sym       = TK_NONE;
        case (c)
            CH_LPAREN: sym = TK_LPAREN;
            CH_RPAREN: sym = TK_RPAREN;
            CH_PLUS:   sym = TK_PLUS;
            CH_MINUS:  sym = TK_MINUS;
            CH_STAR:   sym = TK_STAR;
            CH_SLASH:  sym = TK_SLASH;
            CH_EQ:     sym = TK_ASSIGN;
            default:   is_sym = 1'b0;
        endcase
        if (is_sym) begin
            expect_rec(REC_DONE, sym, CH_NUL, cur_line, cur_col, ERR_NONE);
        end else if (blank(c)) begin
        end else if (c == CH_HASH) begin
            lex_state = M_COMMENT;
        end else if (c == CH_LT) begin
            lex_state = M_LT;
        end else if (c == CH_GT) begin
            lex_state = M_GT;
        end else if (c == CH_QUOTE) begin
            lex_state = M_STRING;
        end else if (letter(c)) begin
            lex_state = M_IDENT;
            kw_alive  = '1;
            id_len    = '0;
            take_ident_char(c);
        end else if (decimal(c)) begin
            lex_state = M_NUMBER;
            saw_dot   = 1'b0;
            num_kind  = NK_INT;
            expect_rec(REC_TEXT, TK_INT, c, tok_line, tok_col, ERR_NONE);
        end else begin
            lex_state = M_ERROR;
            expect_rec(REC_ERR, TK_NONE, c, cur_line, cur_col, ERR_CHAR);
        end
    endtask

    task automatic predict_beat(input t_in_item beat);
        int         before_n;
        t_out_rec   tail;
        logic [7:0] c;
        logic [7:0] esc;
        logic       esc_ok;
        before_n = expected_recs.size();
        c        = beat.char_in;
        if (beat.end_of_input) begin
            if (lex_state == M_STRING || lex_state == M_ESCAPE) begin
                expect_rec(REC_ERR, TK_NONE, CH_NUL, tok_line, tok_col, ERR_EOF);
            end else begin
                close_token();
            end
            reset_lexer();
        end else begin
            case (lex_state)
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        lex_state = M_IDLE;
                    end
                end
                M_LT, M_GT: begin
                    if (c == CH_EQ) begin
                        expect_rec(REC_DONE, (lex_state == M_LT) ? TK_LE : TK_GE, CH_NUL,
                                   tok_line, tok_col, ERR_NONE);
                        lex_state = M_IDLE;
                    end else begin
                        close_token();
                        start_token(c);
                    end
                end
                M_IDENT: begin
                    if (letter(c) || decimal(c)) begin
                        take_ident_char(c);
                    end else begin
                        close_token();
                        start_token(c);
                    end
                end
                M_NUMBER: begin
                    if (decimal(c)) begin
                        expect_rec(REC_TEXT, 5'(TK_INT + num_kind), c, tok_line, tok_col,
                                   ERR_NONE);
                    end else if (c == CH_DOT && !saw_dot) begin
                        saw_dot  = 1'b1;
                        num_kind = NK_DOUBLE;
                        expect_rec(REC_TEXT, TK_DOUBLE, c, tok_line, tok_col, ERR_NONE);
                    end else if (c == CH_LOW_F) begin
                        num_kind = NK_FLOAT;
                    end else if (c == CH_LOW_D) begin
                        num_kind = NK_DOUBLE;
                    end else begin
                        close_token();
                        start_token(c);
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        expect_rec(REC_DONE, TK_STRING, CH_NUL, tok_line, tok_col, ERR_NONE);
                        lex_state = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        lex_state = M_ESCAPE;
                    end else begin
                        expect_rec(REC_TEXT, TK_STRING, c, tok_line, tok_col, ERR_NONE);
                    end
                end
                M_ESCAPE: begin
                    esc_ok = 1'b1;
                    case (c)
                        CH_LOW_N:  esc = CH_NL;
                        CH_LOW_T:  esc = CH_TAB;
                        CH_BSLASH: esc = CH_BSLASH;
                        CH_QUOTE:  esc = CH_QUOTE;
                        default: begin
                            esc    = CH_NUL;
                            esc_ok = 1'b0;
                        end
                    endcase
                    if (esc_ok) begin
                        expect_rec(REC_TEXT, TK_STRING, esc, tok_line, tok_col, ERR_NONE);
                        lex_state = M_STRING;
                    end else begin
                        expect_rec(REC_ERR, TK_NONE, c, cur_line, cur_col, ERR_ESCAPE);
                        lex_state = M_ERROR;
                    end
                end
                M_ERROR: ;
                default: start_token(c);
            endcase
            if (c == CH_NL) begin
                if (cur_line != POS_MAX) begin
                    cur_line++;
                end
                cur_col = POS_ONE;
            end else if (cur_col != POS_MAX) begin
                cur_col++;
            end
        end
        if (expected_recs.size() > before_n) begin
            tail             = expected_recs.pop_back();
            tail.last_of_run = 1'b1;
            expected_recs.insert(expected_recs.size(), tail);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    task automatic compare_beat(input t_out_rec got);
        t_out_rec want;
        if (expected_recs.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: record expected none actual %h", $time, got);
            end
        end else begin
            want = expected_recs.pop_front();
            check_field("rec_kind", 16'(want.rec_kind), 16'(got.rec_kind));
            check_field("token_code", 16'(want.token_code), 16'(got.token_code));
            check_field("text_char", 16'(want.text_char), 16'(got.text_char));
            check_field("pos_line", want.pos_line, got.pos_line);
            check_field("pos_column", want.pos_column, got.pos_column);
            check_field("error_code", 16'(want.error_code), 16'(got.error_code));
            check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_lexer();
            expected_recs.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_beat(i_out_rec);
            end
        end
        o_pending    <= expected_recs.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ sim/tb.sv @@
// tb: top level of the script lexer testbench; builds a character stream of
// directed and random token beats and drives it in bursts
// depends on slx_pkg, script_lexer_unit and slx_checker
module tb;
    import slx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either channel
    localparam int RANDOM_BEATS   = 760;
    localparam int DRAIN_CYCLES   = 12;

    // receiver stall styles, each held for a random stretch
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_style;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_in_item i_item  = '0;
    logic     o_stall;
    logic     o_valid;
    t_out_rec o_rec;

    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    t_stall_style stall_style = STALL_NONE;
    int           stall_left  = 0;

    // the whole character stream, built before reset is released
    t_in_item src_beats[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    script_lexer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (o_rec)
    );

    // the checker sees exactly what the block sees on both channels
    slx_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_rec    (o_rec),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ------------------------------------------------------------------
    // stream builders
    // ------------------------------------------------------------------

    task automatic add_char(input logic [7:0] c);
        t_in_item beat;
        beat.char_in      = c;
        beat.end_of_input = 1'b0;
        src_beats.insert(src_beats.size(), beat);
    endtask

    // the character byte of an end beat is don't-care, so randomize it
    task automatic add_end();
        t_in_item beat;
        beat.char_in      = 8'($urandom_range(0, 255));
        beat.end_of_input = 1'b1;
        src_beats.insert(src_beats.size(), beat);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return 8'("a" + r);
        end
        if (r < 52) begin
            return 8'("A" + r - 26);
        end
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 7))
            0:       return CH_TAB;
            1:       return CH_NL;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic string keyword_text(input int k);
        case (k)
            0:       return "mod";
            1:       return "while";
            2:       return "if";
            3:       return "cond";
            4:       return "and";
            5:       return "or";
            6:       return "invokenative";
            7:       return "return";
            8:       return "setvalue";
            9:       return "statics";
            10:      return "locals";
            default: return "fn";
        endcase
    endfunction

    // one well-formed token with random content, now and then a broken one
    task automatic add_random_token();
        int         pick;
        int         n;
        string      s;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            s = "()+-*/=";
            add_char(s[$urandom_range(0, 6)]);
        end else if (pick < 18) begin
            // lone '<' or '>' ends on whatever follows
            add_char($urandom_range(0, 1) ? CH_LT : CH_GT);
            if ($urandom_range(0, 1)) begin
                add_char(CH_EQ);
            end
        end else if (pick < 36) begin
            // keywords, plus near misses one char long or short
            s = keyword_text($urandom_range(0, 11));
            case ($urandom_range(0, 5))
                0: begin
                    add_text(s);
                    add_char(pick_alnum());
                end
                1:       add_text(s.substr(0, s.len() - 2));
                default: add_text(s);
            endcase
        end else if (pick < 50) begin
            // mostly short names, a few past the 15 char length limit
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 6);
            add_char(pick_letter());
            repeat (n - 1) add_char(pick_alnum());
        end else if (pick < 64) begin
            repeat ($urandom_range(1, 4)) add_char(pick_digit());
            if ($urandom_range(0, 1)) begin
                add_char(CH_DOT);
                repeat ($urandom_range(0, 3)) add_char(pick_digit());
            end
            case ($urandom_range(0, 5))
                0: add_char(CH_LOW_F);
                1: add_char(CH_LOW_D);
                2: begin
                    // suffix in the middle, digits keep coming
                    add_char($urandom_range(0, 1) ? CH_LOW_F : CH_LOW_D);
                    add_char(pick_digit());
                end
                default: ;
            endcase
            // a further dot either starts the fraction or is a second dot
            if ($urandom_range(0, 9) == 0) begin
                add_char(CH_DOT);
            end
        end else if (pick < 78) begin
            add_char(CH_QUOTE);
            repeat ($urandom_range(0, 8)) begin
                n = $urandom_range(0, 9);
                if (n < 6) begin
                    c = 8'($urandom_range(32, 126));
                    add_char((c == CH_QUOTE || c == CH_BSLASH) ? CH_UNDER : c);
                end else if (n < 8) begin
                    s = "nt\\\"";
                    add_char(CH_BSLASH);
                    add_char(s[$urandom_range(0, 3)]);
                end else begin
                    // raw bytes, high bit and control chars included
                    c = 8'($urandom_range(0, 255));
                    add_char((c == CH_QUOTE || c == CH_BSLASH) ? CH_NL : c);
                end
            end
            case ($urandom_range(0, 19))
                0: begin
                    // bad escape
                    c = 8'($urandom_range(0, 255));
                    add_char(CH_BSLASH);
                    add_char((c == CH_LOW_N || c == CH_LOW_T || c == CH_BSLASH ||
                              c == CH_QUOTE) ? CH_NUL : c);
                end
                1: begin
                    // end inside a string, sometimes right after a backslash
                    if ($urandom_range(0, 1)) begin
                        add_char(CH_BSLASH);
                    end
                    add_end();
                end
                default: add_char(CH_QUOTE);
            endcase
        end else if (pick < 84) begin
            add_char(CH_HASH);
            repeat ($urandom_range(0, 10)) begin
                c = 8'($urandom_range(0, 255));
                add_char((c == CH_NL) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 9) == 0) begin
                add_end();
            end else begin
                add_char(CH_NL);
            end
        end else if (pick < 91) begin
            repeat ($urandom_range(1, 3)) add_char(pick_space());
        end else if (pick < 94) begin
            // noise, anything goes
            add_char(8'($urandom_range(0, 255)));
        end else begin
            add_end();
        end
        // tokens are often glued together so one ends on a foreign char
        if ($urandom_range(0, 9) < 6) begin
            add_char(pick_space());
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern that switches style every so often
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 2));
            stall_left  = $urandom_range(5, 120);
        end
        stall_left--;
        case (stall_style)
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // watchdog: any beat on either channel restarts the count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        idle_cycles <= ((i_valid && !o_stall) || (o_valid && !i_stall)) ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        int rand_start;
        int burst_left;

        // directed: every symbol, both pairs, '<' ended by '>', '>' ended by a letter
        add_text("(<=>=)+-*/=<>x mod");
        // end completes the pending keyword
        add_end();
        // second dot: number ends, then the dot is an error that sticks
        add_text("1.2.z");
        add_end();
        // top byte inside a string, then a bad escape
        add_char(CH_QUOTE);
        add_char(8'hFF);
        add_text("\\q");
        add_end();
        // end inside a string
        add_text("\"a");
        add_end();
        // zero byte is unrecognized
        add_char(CH_NUL);
        add_end();
        // control byte right after a name is unrecognized
        add_text("ab");
        add_char(8'h01);
        add_end();

        rand_start = src_beats.size();
        while (src_beats.size() - rand_start < RANDOM_BEATS) add_random_token();
        add_end();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender: bursts of random length, most preceded by a random gap
        burst_left = 0;
        foreach (src_beats[i]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            burst_left--;
            i_valid <= 1'b1;
            i_item  <= src_beats[i];
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;

        // pending count is a registered copy of the checker's queue size
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
